// ----- hw/rtl/cse_pkg.sv -----
// Package for the CAN signal extract and insert block.
// Holds the frame size constant, the input and output word structs, the stage structs
// and the byte swap function. It depends on nothing else.
package cse_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int FRAME_BITS  = 8 * FRAME_BYTES;
    localparam int WORD_BYTES  = 8;

    localparam logic FUNC_EXTRACT = 1'b0;
    localparam logic FUNC_INSERT  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [63:0] frame_in;
        logic [63:0] insert_value;
        logic [5:0]  sig_start;
        logic [6:0]  sig_length;
        logic        little_order;
        logic        signed_sig;
    } t_in_word;

    typedef struct packed {
        logic [63:0] frame_out;
        logic [63:0] value_out;
        logic        param_error;
    } t_out_word;

    typedef struct packed {
        logic        func;
        logic        err;
        logic        intel;
        logic        sgn;
        logic [63:0] frame;
        logic [63:0] work;
        logic [63:0] ins;
        logic [63:0] mask;
        logic [63:0] top_bit;
        logic [5:0]  shift;
    } t_s1;

    typedef struct packed {
        logic        func;
        logic        err;
        logic        intel;
        logic        sgn;
        logic [63:0] frame;
        logic [63:0] work;
        logic [63:0] mask;
        logic [63:0] top_bit;
        logic [63:0] ext;
        logic [63:0] ins_mask;
        logic [63:0] ins_bits;
    } t_s2;

    function automatic logic [63:0] byte_swap(input logic [63:0] d);
        logic [63:0] r;
        r = '0;
        for (int k = 0; k < WORD_BYTES; k++) begin
            r[8*k +: 8] = d[8*(WORD_BYTES-1-k) +: 8];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/can_signal_extract_insert.sv -----
// An accepted input word passes through the stage one, stage two and output registers to its output word.
// One word per cycle while the output is not stalled; a stall holds every full stage without loss.
// Stage one decodes the descriptor, stage two runs the barrel shifts, stage three merges.
// Reset (synchronous, active low) clears the stage valid bits only.
// CAN signal extract and insert top level, a three stage pipeline.
// Depends on cse_pkg.
module can_signal_extract_insert (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  cse_pkg::t_in_word i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output cse_pkg::t_out_word o_out_data,
    input  logic              i_out_stall
);
    import cse_pkg::*;

    logic      r_s1_valid, r_s2_valid, r_out_valid;
    t_s1       r_s1, n_s1;
    t_s2       r_s2, n_s2;
    t_out_word r_out, n_out;
    logic      out_adv, s2_adv, s1_adv;

    logic [5:0]  first;
    logic [7:0]  span;
    logic [7:0]  shift_full;
    logic [6:0]  mask_sh;
    logic [6:0]  top_idx;
    logic [63:0] new_work;
    logic [63:0] value;

    assign out_adv    = !r_out_valid || !i_out_stall;
    assign s2_adv     = !r_s2_valid || out_adv;
    assign s1_adv     = !r_s1_valid || s2_adv;
    assign o_in_stall = !s1_adv;

    always_comb begin
        first      = i_in_data.little_order ? i_in_data.sig_start
                   : {i_in_data.sig_start[5:3], ~i_in_data.sig_start[2:0]};
        span       = {2'b00, first} + {1'b0, i_in_data.sig_length};
        shift_full = 8'd64 - span;
        mask_sh    = 7'd64 - i_in_data.sig_length;
        top_idx    = i_in_data.sig_length - 7'd1;

        n_s1.func    = i_in_data.func;
        n_s1.err     = (i_in_data.sig_length == 7'd0) || (i_in_data.sig_length > 7'd64)
                     || (span > 8'(FRAME_BITS));
        n_s1.intel   = i_in_data.little_order;
        n_s1.sgn     = i_in_data.signed_sig;
        n_s1.frame   = i_in_data.frame_in;
        n_s1.work    = i_in_data.little_order ? i_in_data.frame_in
                     : byte_swap(i_in_data.frame_in);
        n_s1.ins     = i_in_data.insert_value;
        n_s1.mask    = ~64'd0 >> mask_sh[5:0];
        n_s1.top_bit = 64'd1 << top_idx[5:0];
        n_s1.shift   = i_in_data.little_order ? first : shift_full[5:0];
    end

    always_comb begin
        n_s2.func     = r_s1.func;
        n_s2.err      = r_s1.err;
        n_s2.intel    = r_s1.intel;
        n_s2.sgn      = r_s1.sgn;
        n_s2.frame    = r_s1.frame;
        n_s2.work     = r_s1.work;
        n_s2.mask     = r_s1.mask;
        n_s2.top_bit  = r_s1.top_bit;
        n_s2.ext      = r_s1.work >> r_s1.shift;
        n_s2.ins_mask = r_s1.mask << r_s1.shift;
        n_s2.ins_bits = (r_s1.ins & r_s1.mask) << r_s1.shift;
    end

    always_comb begin
        new_work = (r_s2.work & ~r_s2.ins_mask) | r_s2.ins_bits;
        value    = r_s2.ext & r_s2.mask;
        if (r_s2.sgn && ((r_s2.ext & r_s2.top_bit) != 64'd0)) begin
            value = value | ~r_s2.mask;
        end
        n_out.param_error = r_s2.err;
        if (r_s2.err) begin
            n_out.frame_out = r_s2.frame;
            n_out.value_out = '0;
        end else if (r_s2.func == FUNC_INSERT) begin
            n_out.frame_out = r_s2.intel ? new_work : byte_swap(new_work);
            n_out.value_out = '0;
        end else begin
            n_out.frame_out = r_s2.frame;
            n_out.value_out = value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1 <= n_s1;
        end
        if (s2_adv) begin
            r_s2 <= n_s2;
        end
        if (out_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hw/rtl/cse_checker.sv -----
// Port checker for the CAN signal extract and insert block, with its bind statement.
// Depends on cse_pkg and on the top level can_signal_extract_insert.
module cse_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input cse_pkg::t_in_word  i_in_data,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input cse_pkg::t_out_word o_out_data,
    input logic               i_out_stall
);
    import cse_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("Stalled output word changed.");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.param_error |-> o_out_data.value_out == 64'd0)
        else $error("Error word carries a nonzero value.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall ##1 !i_out_stall |=> o_out_valid)
        else $error("Accepted word did not reach the output in three cycles.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid after reset.");

endmodule

bind can_signal_extract_insert cse_checker u_cse_checker (.*);

// ----- test/can_signal_monitor.sv -----
`timescale 1ns / 1ps
// Monitor for the CAN signal extract and insert block: watches both channels,
// predicts each result word from the accepted input word and compares field by field.
// Depends on cse_pkg for the word structs, the function codes and the frame size.
module can_signal_monitor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  cse_pkg::t_in_word  i_in_data,
    input  logic               i_in_stall,
    input  logic               i_out_valid,
    input  cse_pkg::t_out_word i_out_data,
    input  logic               i_out_stall,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_flagged
);
    import cse_pkg::*;

    t_out_word expected_words[$];
    int        fails   = 0;
    int        pending = 0;
    int        checked = 0;
    int        flagged = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;
    assign o_checked    = checked;
    assign o_flagged    = flagged;

    function automatic t_out_word unpack_or_pack(input t_in_word w);
        t_out_word   r;
        logic [63:0] frame;
        logic [63:0] value;
        int          first;
        int          len;
        int          lin;
        int          pos;
        int          vb;
        frame = w.frame_in;
        value = '0;
        len   = int'(w.sig_length);
        if (w.little_order) begin
            first = int'(w.sig_start);
        end else begin
            first = int'({w.sig_start[5:3], ~w.sig_start[2:0]});
        end
        r.frame_out   = frame;
        r.value_out   = '0;
        r.param_error = 1'b1;
        if (len == 0 || len > 64 || first + len > FRAME_BITS) begin
            return r;
        end
        for (int i = 0; i < len; i++) begin
            lin = first + i;
            pos = w.little_order ? lin : (lin / 8) * 8 + 7 - (lin % 8);
            vb  = w.little_order ? i : len - 1 - i;
            if (w.func == FUNC_INSERT) begin
                frame[pos] = w.insert_value[vb];
            end else if (frame[pos]) begin
                value[vb] = 1'b1;
            end
        end
        if (w.func == FUNC_INSERT) begin
            value = '0;
        end else if (w.signed_sig && len < 64 && value[len-1]) begin
            value = value | ({64{1'b1}} << len);
        end
        r.frame_out   = frame;
        r.value_out   = value;
        r.param_error = 1'b0;
        return r;
    endfunction

    task automatic note_fail(input string what, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
        if (fails < 10) begin
            $display("[%0t] mismatch in %s: expected %h, got %h", $realtime, what, exp_v, act_v);
        end
        fails++;
    endtask

    always @(posedge i_clk) begin : watch
        t_out_word exp_w;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    note_fail("unexpected word", '0, i_out_data.frame_out);
                end else begin
                    exp_w = expected_words.pop_front();
                    checked++;
                    if (exp_w.param_error) begin
                        flagged++;
                    end
                    if (exp_w.frame_out !== i_out_data.frame_out) begin
                        note_fail("frame_out", exp_w.frame_out, i_out_data.frame_out);
                    end
                    if (exp_w.value_out !== i_out_data.value_out) begin
                        note_fail("value_out", exp_w.value_out, i_out_data.value_out);
                    end
                    if (exp_w.param_error !== i_out_data.param_error) begin
                        note_fail("param_error", 64'(exp_w.param_error),
                                  64'(i_out_data.param_error));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_words.push_back(unpack_or_pack(i_in_data));
            end
            pending = expected_words.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the testbench for the CAN signal extract and insert block: clock, reset,
// directed and random input words, output stalls, watchdog and verdict.
// Depends on cse_pkg, can_signal_extract_insert and can_signal_monitor.
module tb_top;
    import cse_pkg::*;

    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 10;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;
    logic      out_stall = 1'b0;

    int fail_count;
    int pending;
    int checked;
    int flagged;
    int sent       = 0;
    int tx_max_gap = 12;
    int rx_max_gap = 12;
    bit hold_req   = 1'b0;

    always #5 clk = ~clk;

    can_signal_extract_insert dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_word),
        .i_out_stall (out_stall)
    );

    can_signal_monitor u_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_data    (in_word),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_data   (out_word),
        .i_out_stall  (out_stall),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_flagged    (flagged)
    );

    function automatic logic [63:0] rand_frame();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_in_word rand_word();
        t_in_word w;
        int       first;
        int       room;
        w.func         = $urandom_range(0, 1) ? FUNC_INSERT : FUNC_EXTRACT;
        w.frame_in     = rand_frame();
        w.insert_value = rand_frame();
        w.sig_start    = 6'($urandom_range(0, 63));
        w.little_order = 1'($urandom_range(0, 1));
        w.signed_sig   = 1'($urandom_range(0, 1));
        first = w.little_order ? int'(w.sig_start)
              : int'({w.sig_start[5:3], ~w.sig_start[2:0]});
        room  = 64 - first;
        case ($urandom_range(0, 9))
            0: w.sig_length = 7'($urandom_range(0, 127));
            1: w.sig_length = 7'(room + int'($urandom_range(1, 63)));
            default: w.sig_length = 7'($urandom_range(1, room));
        endcase
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic send_desc(input logic func, input int sb, input int len,
                             input logic intel, input logic sgn,
                             input logic [63:0] frame, input logic [63:0] ins);
        t_in_word w;
        w.func         = func;
        w.frame_in     = frame;
        w.insert_value = ins;
        w.sig_start    = 6'(sb);
        w.sig_length   = 7'(len);
        w.little_order = intel;
        w.signed_sig   = sgn;
        send_word(w);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_word(rand_word());
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin : receiver
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = $urandom_range(0, rx_max_gap);
            end
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("[%0t] watchdog: no word moved for %0d cycles", $realtime, IDLE_LIMIT);
        $display("** can_signal_extract_insert: FAILED **");
        $finish;
    end

    initial begin : stimulus
        wait (rst_n);
        @(posedge clk);

        // Directed words: length and position extremes, both bit orders, both functions.
        send_desc(FUNC_EXTRACT, 0, 64, 1'b1, 1'b1, '1, '0);
        send_desc(FUNC_EXTRACT, 0, 1, 1'b1, 1'b1, 64'h1, '0);
        send_desc(FUNC_EXTRACT, 63, 1, 1'b1, 1'b0, '1, '0);
        send_desc(FUNC_EXTRACT, 63, 2, 1'b1, 1'b0, '1, '0);
        send_desc(FUNC_EXTRACT, 0, 0, 1'b1, 1'b0, rand_frame(), '0);
        send_desc(FUNC_EXTRACT, 0, 65, 1'b1, 1'b1, rand_frame(), '0);
        send_desc(FUNC_INSERT, 0, 127, 1'b1, 1'b0, rand_frame(), '1);
        send_desc(FUNC_EXTRACT, 7, 64, 1'b0, 1'b1, {$urandom, $urandom}, '0);
        send_desc(FUNC_EXTRACT, 0, 1, 1'b0, 1'b1, '1, '0);
        send_desc(FUNC_EXTRACT, 56, 8, 1'b0, 1'b0, '1, '0);
        send_desc(FUNC_EXTRACT, 63, 8, 1'b0, 1'b1, 64'h8000_0000_0000_0000, '0);
        send_desc(FUNC_EXTRACT, 12, 20, 1'b0, 1'b1, {$urandom, $urandom}, '0);
        send_desc(FUNC_EXTRACT, 4, 12, 1'b1, 1'b1, 64'h0000_0000_0000_8000, '0);
        send_desc(FUNC_EXTRACT, 8, 56, 1'b1, 1'b1, '1, '0);
        send_desc(FUNC_INSERT, 0, 64, 1'b1, 1'b0, '0, {$urandom, $urandom});
        send_desc(FUNC_INSERT, 7, 64, 1'b0, 1'b0, '1, {$urandom, $urandom});
        send_desc(FUNC_INSERT, 12, 20, 1'b0, 1'b1, {$urandom, $urandom}, '1);
        send_desc(FUNC_INSERT, 60, 4, 1'b1, 1'b1, '0, '1);
        send_desc(FUNC_INSERT, 61, 4, 1'b1, 1'b0, '0, '1);
        send_desc(FUNC_INSERT, 63, 1, 1'b0, 1'b0, '0, '1);
        send_desc(FUNC_EXTRACT, 7, 57, 1'b0, 1'b0, {$urandom, $urandom}, '0);
        send_desc(FUNC_INSERT, 0, 1, 1'b1, 1'b1, '1, '0);
        drain();

        run_random(300);
        drain();

        // Back-to-back words against a long output hold, so the pipeline fills.
        tx_max_gap = 0;
        rx_max_gap = 0;
        hold_req   = 1'b1;
        run_random(200);
        drain();

        rx_max_gap = 12;
        run_random(250);
        drain();

        tx_max_gap = 12;
        rx_max_gap = 0;
        run_random(250);
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d words; checked %0d results, %0d of them with a bad descriptor.",
                 sent, checked, flagged);
        $display("Idle profiles varied per phase, with one %0d-cycle output hold.",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("** can_signal_extract_insert: PASSED **");
        end else begin
            $display("** can_signal_extract_insert: FAILED **");
        end
        $finish;
    end

endmodule
